### rtl/core/pte_pkg.sv
`timescale 1ns / 1ps

package pte_pkg;

    // Parse steps of the PES header walker.
    typedef enum logic [3:0] {
        PH_SEARCH     = 4'd0,
        PH_ID         = 4'd1,
        PH_LEN_HI     = 4'd2,
        PH_LEN_LO     = 4'd3,
        PH_STUFF      = 4'd4,
        PH_STD        = 4'd5,
        PH_MP1_PTS    = 4'd6,
        PH_MP2_FLAGS  = 4'd7,
        PH_MP2_HDRLEN = 4'd8,
        PH_MP2_PTS    = 4'd9,
        PH_PTS1       = 4'd10,
        PH_PTS2       = 4'd11,
        PH_PTS3       = 4'd12,
        PH_PTS4       = 4'd13,
        PH_SKIP       = 4'd14,
        PH_DONE       = 4'd15
    } phase_t;

    // One request from the parser to the back end.
    typedef struct packed {
        logic        found;
        logic [32:0] ticks;
    } result_t;

    localparam logic [23:0] START_CODE = 24'h000001;
    localparam logic [7:0]  AUDIO_LO   = 8'hC0;
    localparam logic [7:0]  AUDIO_HI   = 8'hCF;
    localparam logic [7:0]  VIDEO_LO   = 8'hE0;
    localparam logic [7:0]  VIDEO_HI   = 8'hEF;

    // Top two bits of a header byte.
    localparam logic [1:0] HDR_STUFFING = 2'b11;
    localparam logic [1:0] HDR_STD      = 2'b01;
    localparam logic [1:0] HDR_MPEG2    = 2'b10;
    localparam logic [1:0] HDR_MPEG1    = 2'b00;
    localparam logic [2:0] MP2_PTS_MARK = 3'b001;

    // Bytes that must follow the first PTS byte inside the packet.
    localparam logic [16:0] PTS_TAIL = 17'd5;

    // 90000 = 16 * 5625: drop four bits, then multiply the 29-bit rest by
    // ceil(2^42 / 5625) and keep the bits from 42 up. The rounding error stays
    // below one quotient step for every 29-bit dividend.
    localparam int          TICK_SHIFT      = 4;
    localparam logic [29:0] DIV_RECIP       = 30'd781874936;
    localparam int          DIV_RECIP_SHIFT = 42;

    localparam int QUEUE_DEPTH = 4;

endpackage

### rtl/core/pes_timestamp_extractor.sv
// PES timestamp extractor. Takes one byte per clock (byte_valid/byte_stall)
// and finds the first presentation timestamp of each buffer, the buffer end
// being marked by last_in_buffer. It gives one request per buffer on the
// result side: found=1 with the 33-bit PTS in 90 kHz ticks and in whole
// seconds, issued on the last PTS byte, or found=0 with zeros, issued on
// the last byte when the buffer held none. The parser keeps one byte per
// cycle unless stalled; requests pass a four-entry queue into a two-stage
// divide-by-90000 pipeline (an operand register, then a reciprocal multiply
// into the result register), which also delivers one request per cycle
// unless the result side stalls. Requests go from the queue through the
// operand register into the result register. byte_stall rises only while
// the queue is full, which happens only when the result side stalls.
`timescale 1ns / 1ps

module pes_timestamp_extractor
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_in_buffer,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [32:0] timestamp_ticks,
    output logic [16:0] timestamp_seconds
);

    logic    byte_fire;
    logic    push;
    result_t push_data;
    logic    queue_full;
    logic    queue_empty;
    logic    pop;
    result_t queue_data;

    assign byte_stall = queue_full;
    assign byte_fire  = byte_valid && !queue_full;

    // Front: header parsing.
    pte_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_fire      (byte_fire),
        .data_byte      (data_byte),
        .last_in_buffer (last_in_buffer),
        .push           (push),
        .push_data      (push_data)
    );

    // Decoupling queue.
    pte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (queue_data),
        .empty     (queue_empty)
    );

    // Back: seconds conversion and result register.
    pte_divider u_divider (
        .clk               (clk),
        .rst_n             (rst_n),
        .queue_empty       (queue_empty),
        .queue_data        (queue_data),
        .pop               (pop),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .found             (found),
        .timestamp_ticks   (timestamp_ticks),
        .timestamp_seconds (timestamp_seconds)
    );

endmodule

### rtl/core/pte_front.sv
`timescale 1ns / 1ps

module pte_front
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    input  logic        last_in_buffer,
    output logic        push,
    output result_t     push_data
);

    phase_t      phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [32:0] accum_reg, accum_next;

    logic [23:0] search_win;
    logic [15:0] search_cnt;
    logic        search_hit;
    logic        is_stream_id;
    logic        at_end;
    logic        pts_flag;
    logic        pts_go;
    logic        hit;

    // Shared decode of the current byte.
    always_comb
    begin
        search_win   = {window_reg[15:0], data_byte};
        search_cnt   = (offset_reg < 16'd3) ? offset_reg + 16'd1 : offset_reg;
        search_hit   = (search_cnt >= 16'd3) && (search_win == START_CODE);
        is_stream_id = ((data_byte >= AUDIO_LO) && (data_byte <= AUDIO_HI))
                    || ((data_byte >= VIDEO_LO) && (data_byte <= VIDEO_HI));
        at_end       = offset_reg >= length_reg;
        pts_flag     = (phase_reg == PH_MP2_PTS) ? (data_byte[7:5] == MP2_PTS_MARK)
                                                 : data_byte[5];
        pts_go       = pts_flag && (({1'b0, offset_reg} + PTS_TAIL) < {1'b0, length_reg});
        hit          = (phase_reg == PH_PTS4) && !at_end;
    end

    // Next parse step.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SEARCH:  phase_next = search_hit ? PH_ID : PH_SEARCH;
            PH_ID:      phase_next = is_stream_id ? PH_LEN_HI : PH_SEARCH;
            PH_LEN_HI:  phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = PH_STUFF;
            PH_DONE:    phase_next = PH_DONE;
            PH_STUFF, PH_STD, PH_MP1_PTS, PH_MP2_FLAGS, PH_MP2_HDRLEN, PH_MP2_PTS,
            PH_PTS1, PH_PTS2, PH_PTS3, PH_PTS4, PH_SKIP:
            begin
                if (at_end)
                begin
                    phase_next = PH_SEARCH;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_STUFF:
                        begin
                            unique case (data_byte[7:6])
                                HDR_STUFFING: phase_next = PH_STUFF;
                                HDR_STD:      phase_next = PH_STD;
                                HDR_MPEG2:    phase_next = PH_MP2_FLAGS;
                                HDR_MPEG1:    phase_next = pts_go ? PH_PTS1 : PH_SKIP;
                            endcase
                        end
                        PH_STD:        phase_next = PH_MP1_PTS;
                        PH_MP1_PTS:    phase_next = pts_go ? PH_PTS1 : PH_SKIP;
                        PH_MP2_FLAGS:  phase_next = data_byte[7] ? PH_MP2_HDRLEN : PH_SKIP;
                        PH_MP2_HDRLEN: phase_next = PH_MP2_PTS;
                        PH_MP2_PTS:    phase_next = pts_go ? PH_PTS1 : PH_SKIP;
                        PH_PTS1:       phase_next = PH_PTS2;
                        PH_PTS2:       phase_next = PH_PTS3;
                        PH_PTS3:       phase_next = PH_PTS4;
                        PH_PTS4:       phase_next = PH_DONE;
                        default:       phase_next = PH_SKIP;
                    endcase
                end
            end
        endcase
        if (last_in_buffer)
        begin
            phase_next = PH_SEARCH;
        end
    end

    // Datapath registers and the request toward the back end.
    always_comb
    begin
        window_next = window_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        accum_next  = accum_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                window_next = search_win;
                offset_next = search_cnt;
            end
            PH_ID:
            begin
                if (!is_stream_id)
                begin
                    window_next = '0;
                    offset_next = '0;
                end
            end
            PH_LEN_HI: length_next = {data_byte, 8'h00};
            PH_LEN_LO:
            begin
                length_next = {length_reg[15:8], data_byte};
                offset_next = '0;
            end
            PH_DONE: ;
            default:
            begin
                if (at_end)
                begin
                    // Packet ended: this byte is the first one of a new search.
                    window_next = {16'h0000, data_byte};
                    offset_next = 16'd1;
                end
                else
                begin
                    offset_next = offset_reg + 16'd1;
                    if (((phase_reg == PH_STUFF) && (data_byte[7:6] == HDR_MPEG1))
                        || (phase_reg == PH_MP1_PTS) || (phase_reg == PH_MP2_PTS))
                    begin
                        accum_next = {data_byte[3:1], 30'h0};
                    end
                    else if (phase_reg == PH_PTS1)
                    begin
                        accum_next = accum_reg | {3'b000, data_byte, 22'h0};
                    end
                    else if (phase_reg == PH_PTS2)
                    begin
                        accum_next = accum_reg | {11'h000, data_byte[7:1], 15'h0000};
                    end
                    else if (phase_reg == PH_PTS3)
                    begin
                        accum_next = accum_reg | {18'h00000, data_byte, 7'h00};
                    end
                    else if (phase_reg == PH_PTS4)
                    begin
                        accum_next = accum_reg | {26'h0000000, data_byte[7:1]};
                    end
                end
            end
        endcase
        if (last_in_buffer)
        begin
            window_next = '0;
            offset_next = '0;
            length_next = '0;
            accum_next  = '0;
        end

        push            = byte_fire && (hit || (last_in_buffer && (phase_reg != PH_DONE)));
        push_data.found = hit;
        push_data.ticks = hit ? (accum_reg | {26'h0000000, data_byte[7:1]}) : 33'h0;
    end

    // Parse state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            window_reg <= '0;
            offset_reg <= '0;
            length_reg <= '0;
            accum_reg  <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            accum_reg  <= accum_next;
        end
    end

endmodule

### rtl/core/pte_queue.sv
`timescale 1ns / 1ps

module pte_queue
    import pte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output result_t pop_data,
    output logic    empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    result_t            slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        full     = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
        empty    = count_reg == '0;
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = slot_reg[rd_ptr_reg];
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/pte_divider.sv
`timescale 1ns / 1ps

module pte_divider
    import pte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  result_t     queue_data,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [32:0] timestamp_ticks,
    output logic [16:0] timestamp_seconds
);

    logic        stage_valid_reg;
    result_t     stage_res_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic [16:0] out_sec_reg;
    logic [58:0] product;
    logic        advance;

    // The whole pipeline moves unless the result at its end is held.
    assign advance = !(out_valid_reg && result_stall);
    assign pop     = advance && !queue_empty;

    // Seconds: ticks/16 times the scaled reciprocal of 5625, quotient in the top bits.
    assign product = 59'(stage_res_reg.ticks[32:TICK_SHIFT]) * 59'(DIV_RECIP);

    // Valid flags of the operand and result stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= !queue_empty;
            out_valid_reg   <= stage_valid_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_res_reg <= queue_data;
            out_res_reg   <= stage_res_reg;
            out_sec_reg   <= product[DIV_RECIP_SHIFT +: 17];
        end
    end

    assign result_valid      = out_valid_reg;
    assign found             = out_res_reg.found;
    assign timestamp_ticks   = out_res_reg.ticks;
    assign timestamp_seconds = out_sec_reg;

endmodule

### rtl/core/pte_checker.sv
`timescale 1ns / 1ps

module pte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic        found,
    input logic [32:0] timestamp_ticks,
    input logic [16:0] timestamp_seconds
);

    logic [49:0] sec_lo;
    logic [49:0] sec_hi;

    assign sec_lo = 50'(timestamp_seconds) * 50'd90000;
    assign sec_hi = sec_lo + 50'd90000;

    // A held request keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(found)
            && $stable(timestamp_ticks) && $stable(timestamp_seconds))
        else $error("result changed while stalled");

    // A not-found request carries zeros.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> timestamp_ticks == 33'h0 && timestamp_seconds == 17'h0)
        else $error("not-found request with nonzero timestamp");

    // Seconds are the whole quotient of ticks by 90000.
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sec_lo <= 50'(timestamp_ticks) && 50'(timestamp_ticks) < sec_hi)
        else $error("seconds do not match ticks");

    // Input is never held off while the result side is free to take requests.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid ##1 !result_valid |-> !byte_stall)
        else $error("byte stall without back pressure");

endmodule

bind pes_timestamp_extractor pte_checker u_pte_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .byte_stall        (byte_stall),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .found             (found),
    .timestamp_ticks   (timestamp_ticks),
    .timestamp_seconds (timestamp_seconds)
);
